[rtl/lfu_pkg.sv]
// shared types and constants for the lfu page replacement block
package lfu_pkg;

   // frames built into the table
   localparam int FRAMES = 16;
   // bits of a frame index and of a frame count
   localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CNT_W = $clog2(FRAMES + 1);

   localparam int PAGE_W  = 16;
   localparam int COUNT_W = 16;
   localparam int SLOT_W  = 4;
   localparam int CFG_W   = 5;

   localparam int APB_AW = 2;
   localparam int APB_DW = 32;

   // byte address of the frames_in_use register
   localparam logic [APB_AW-1:0] ADDR_FRAMES_IN_USE = 2'd0;

   // reset value of frames_in_use
   localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = 5'd16;

   // one table entry: resident page and its use count
   typedef struct packed {
      logic [PAGE_W-1:0]  page;
      logic [COUNT_W-1:0] count;
   } entry_type;

endpackage

[rtl/lfu_page_replacement.sv]
// top level of the lfu page replacement block: scan, update and result
// Least-frequently-used page frame policy, fully associative.
// req channel: one page reference per item (req_valid, req_stall, req_page).
// rsp channel: one result per item: hit flag, frame slot now holding the page,
//   and the evicted page when a resident page was replaced.
// Configuration: frames_in_use at byte address 0 of the APB port; write it only
//   while the block is idle. 0 acts as 1, values above the built count clamp.
// Page and use count of each frame share one synchronous table (registered read).
// An item is handled in order: the table scan reads one frame after another and
//   finds the hit and the lowest-index minimum count together, the last read
//   returns, and the write-back stores the table entry and loads the result.
// Items are taken one at a time; req_stall is high from accept until the
//   result moves into the output register, so a new item is not taken before
//   the result of the last one is loaded.
// A finished result waits in the output register while rsp_stall is high; the
//   next item is accepted and scanned meanwhile and waits before its write-back
//   until the register is free.
// Reset clears the fill count, the control state and the output valid flag and
//   loads frames_in_use with 16; table contents need no clearing.
module lfu_page_replacement (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [lfu_pkg::PAGE_W-1:0]     req_page,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_hit,
   output logic [lfu_pkg::SLOT_W-1:0]     rsp_frame_slot,
   output logic                           rsp_evicted_valid,
   output logic [lfu_pkg::PAGE_W-1:0]     rsp_evicted_page,
   // configuration port
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [lfu_pkg::APB_AW-1:0]     paddr,
   input  logic [lfu_pkg::APB_DW-1:0]     pwdata,
   output logic [lfu_pkg::APB_DW-1:0]     prdata,
   output logic                           pready
);

   localparam int IDX_W   = lfu_pkg::IDX_W;
   localparam int CNT_W   = lfu_pkg::CNT_W;
   localparam int PAGE_W  = lfu_pkg::PAGE_W;
   localparam int COUNT_W = lfu_pkg::COUNT_W;
   localparam int CFG_W   = lfu_pkg::CFG_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type             state_ff, state_in;
   logic [CFG_W-1:0]      frames_ff, frames_in;
   logic [CNT_W-1:0]      filled_ff, filled_in;
   logic [PAGE_W-1:0]     page_ff, page_in;
   logic [CNT_W-1:0]      n_ff, n_in;
   logic [CNT_W-1:0]      resident_ff, resident_in;
   logic [CNT_W-1:0]      scan_idx_ff, scan_idx_in;
   logic                  chk_vld_ff, chk_vld_in;
   logic [CNT_W-1:0]      chk_idx_ff, chk_idx_in;
   logic                  hit_ff, hit_in;
   logic [IDX_W-1:0]      hit_idx_ff, hit_idx_in;
   logic [COUNT_W-1:0]    hit_cnt_ff, hit_cnt_in;
   logic [IDX_W-1:0]      min_idx_ff, min_idx_in;
   logic [COUNT_W-1:0]    min_cnt_ff, min_cnt_in;
   logic [PAGE_W-1:0]     min_page_ff, min_page_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [IDX_W-1:0]      rsp_slot_ff, rsp_slot_in;
   logic                  rsp_ev_valid_ff, rsp_ev_valid_in;
   logic [PAGE_W-1:0]     rsp_ev_page_ff, rsp_ev_page_in;

   lfu_pkg::entry_type    table_mem [lfu_pkg::FRAMES];
   lfu_pkg::entry_type    rd_data_ff;
   logic [IDX_W-1:0]      rd_addr;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   lfu_pkg::entry_type    wr_data;

   logic                  req_accept;
   logic                  cfg_write;
   logic                  out_free;
   logic [CNT_W-1:0]      n_eff;

   // handshakes
   assign req_accept = req_valid && (state_ff == ST_IDLE);
   assign req_stall  = (state_ff != ST_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign cfg_write  = psel && penable && pwrite && (paddr == lfu_pkg::ADDR_FRAMES_IN_USE);

   // config port
   assign pready = 1'b1;
   assign prdata = (paddr == lfu_pkg::ADDR_FRAMES_IN_USE) ?
                   lfu_pkg::APB_DW'(frames_ff) : '0;

   // effective frame count, clamped to 1..FRAMES
   always_comb begin
      if (frames_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if ({3'b000, frames_ff} > 8'(lfu_pkg::FRAMES)) begin
         n_eff = CNT_W'(lfu_pkg::FRAMES);
      end else begin
         n_eff = CNT_W'(frames_ff);
      end
   end

   // result ports
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_slot    = lfu_pkg::SLOT_W'(rsp_slot_ff);
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_page  = rsp_ev_page_ff;

   // table read address follows the scan pointer
   assign rd_addr = scan_idx_ff[IDX_W-1:0];

   // next state, scan compare and write-back
   always_comb begin
      state_in        = state_ff;
      frames_in       = frames_ff;
      filled_in       = filled_ff;
      page_in         = page_ff;
      n_in            = n_ff;
      resident_in     = resident_ff;
      scan_idx_in     = scan_idx_ff;
      chk_vld_in      = 1'b0;
      chk_idx_in      = scan_idx_ff;
      hit_in          = hit_ff;
      hit_idx_in      = hit_idx_ff;
      hit_cnt_in      = hit_cnt_ff;
      min_idx_in      = min_idx_ff;
      min_cnt_in      = min_cnt_ff;
      min_page_in     = min_page_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_hit_in      = rsp_hit_ff;
      rsp_slot_in     = rsp_slot_ff;
      rsp_ev_valid_in = rsp_ev_valid_ff;
      rsp_ev_page_in  = rsp_ev_page_ff;
      wr_en           = 1'b0;
      wr_addr         = hit_idx_ff;
      wr_data         = '{page: page_ff, count: COUNT_W'(1)};

      if (cfg_write) begin
         frames_in = pwdata[CFG_W-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               page_in     = req_page;
               n_in        = n_eff;
               resident_in = (filled_ff < n_eff) ? filled_ff : n_eff;
               scan_idx_in = '0;
               hit_in      = 1'b0;
               state_in    = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // issue one read per frame
            if (scan_idx_ff != n_ff) begin
               chk_vld_in  = 1'b1;
               scan_idx_in = scan_idx_ff + CNT_W'(1);
            end
            // compare the entry that came back
            if (chk_vld_ff) begin
               if (!hit_ff && (chk_idx_ff < resident_ff) &&
                   (rd_data_ff.page == page_ff)) begin
                  hit_in     = 1'b1;
                  hit_idx_in = chk_idx_ff[IDX_W-1:0];
                  hit_cnt_in = rd_data_ff.count;
               end
               if ((chk_idx_ff == '0) || (rd_data_ff.count < min_cnt_ff)) begin
                  min_idx_in  = chk_idx_ff[IDX_W-1:0];
                  min_cnt_in  = rd_data_ff.count;
                  min_page_in = rd_data_ff.page;
               end
               if (chk_idx_ff == n_ff - CNT_W'(1)) begin
                  state_in = ST_FINISH;
               end
            end
         end

         ST_FINISH: begin
            if (out_free) begin
               wr_en        = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit_ff;
               if (hit_ff) begin
                  // hit: bump the count, saturating
                  wr_addr         = hit_idx_ff;
                  wr_data.count   = (hit_cnt_ff == '1) ? hit_cnt_ff
                                                       : hit_cnt_ff + COUNT_W'(1);
                  rsp_slot_in     = hit_idx_ff;
                  rsp_ev_valid_in = 1'b0;
                  rsp_ev_page_in  = '0;
               end else if (filled_ff < n_ff) begin
                  // miss with a free frame
                  wr_addr         = filled_ff[IDX_W-1:0];
                  rsp_slot_in     = filled_ff[IDX_W-1:0];
                  rsp_ev_valid_in = 1'b0;
                  rsp_ev_page_in  = '0;
                  filled_in       = filled_ff + CNT_W'(1);
               end else begin
                  // miss with all frames full: replace the least used
                  wr_addr         = min_idx_ff;
                  rsp_slot_in     = min_idx_ff;
                  rsp_ev_valid_in = 1'b1;
                  rsp_ev_page_in  = min_page_ff;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         frames_ff    <= lfu_pkg::FRAMES_IN_USE_RST;
         filled_ff    <= '0;
         chk_vld_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         frames_ff    <= frames_in;
         filled_ff    <= filled_in;
         chk_vld_ff   <= chk_vld_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      page_ff         <= page_in;
      n_ff            <= n_in;
      resident_ff     <= resident_in;
      scan_idx_ff     <= scan_idx_in;
      chk_idx_ff      <= chk_idx_in;
      hit_idx_ff      <= hit_idx_in;
      hit_cnt_ff      <= hit_cnt_in;
      min_idx_ff      <= min_idx_in;
      min_cnt_ff      <= min_cnt_in;
      min_page_ff     <= min_page_in;
      rsp_hit_ff      <= rsp_hit_in;
      rsp_slot_ff     <= rsp_slot_in;
      rsp_ev_valid_ff <= rsp_ev_valid_in;
      rsp_ev_page_ff  <= rsp_ev_page_in;
   end

   // frame table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   // an accepted item always starts a scan
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == ST_SCAN)
      else $error("accepted item did not start a scan");

   // fill count never passes the built frame count
   assert property (@(posedge clock) disable iff (reset)
      filled_ff <= CNT_W'(lfu_pkg::FRAMES))
      else $error("fill count beyond frame count");

   // fill count only steps up by one, on a miss write-back
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && (filled_ff != $past(filled_ff)) |->
         (filled_ff == $past(filled_ff) + CNT_W'(1)) && !rsp_hit_ff)
      else $error("fill count changed unexpectedly");

   // a result never reports both a hit and an eviction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_hit_ff && rsp_ev_valid_ff))
      else $error("hit and eviction reported together");

   // the table is only written while the result register takes the item
   assert property (@(posedge clock) disable iff (reset)
      wr_en |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("table write without a result");

endmodule

[dv/tb_top.sv]
// testbench for the lfu page replacement block: page references checked against a local lfu model
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT   = 4000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 500;
   localparam int HOLD_AFTER   = 120;
   localparam logic [lfu_pkg::PAGE_W-1:0] HOT_PAGE = 16'hBEEF;

   typedef struct packed {
      logic                       hit;
      logic [lfu_pkg::SLOT_W-1:0] slot;
      logic                       ev_valid;
      logic [lfu_pkg::PAGE_W-1:0] ev_page;
   } reply_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [lfu_pkg::PAGE_W-1:0]   req_page = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic                         rsp_hit;
   logic [lfu_pkg::SLOT_W-1:0]   rsp_frame_slot;
   logic                         rsp_evicted_valid;
   logic [lfu_pkg::PAGE_W-1:0]   rsp_evicted_page;
   logic                         psel = 1'b0;
   logic                         penable = 1'b0;
   logic                         pwrite = 1'b0;
   logic [lfu_pkg::APB_AW-1:0]   paddr = '0;
   logic [lfu_pkg::APB_DW-1:0]   pwdata = '0;
   logic [lfu_pkg::APB_DW-1:0]   prdata;
   logic                         pready;

   // local copy of the frame table and the configuration
   logic [lfu_pkg::PAGE_W-1:0]   tbl_page [lfu_pkg::FRAMES];
   logic [lfu_pkg::COUNT_W-1:0]  tbl_count [lfu_pkg::FRAMES];
   int unsigned                  tbl_filled = 0;
   logic [lfu_pkg::CFG_W-1:0]    cfg_frames = lfu_pkg::FRAMES_IN_USE_RST;

   logic [lfu_pkg::PAGE_W-1:0]   page_q [$];
   reply_type                    replies_due [$];
   int                           n_queued = 0;
   int                           n_taken = 0;
   int                           n_checked = 0;
   int                           n_errors = 0;

   lfu_page_replacement DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_page          (req_page),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hit           (rsp_hit),
      .rsp_frame_slot    (rsp_frame_slot),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   // clock
   initial begin
      forever #4 clock = ~clock;
   end

   // lfu lookup and update for one page reference
   function automatic reply_type lfu_access(input logic [lfu_pkg::PAGE_W-1:0] page);
      int unsigned n;
      int unsigned resident;
      int unsigned slot;
      int unsigned i;
      reply_type   r;
      if (cfg_frames == '0)
         n = 1;
      else if (cfg_frames > lfu_pkg::FRAMES)
         n = lfu_pkg::FRAMES;
      else
         n = int'(cfg_frames);
      resident = (tbl_filled < n) ? tbl_filled : n;
      r = '0;
      slot = 0;
      for (i = 0; i < resident; i++) begin
         if (!r.hit && tbl_page[i] == page) begin
            r.hit = 1'b1;
            slot = i;
         end
      end
      if (r.hit) begin
         if (tbl_count[slot] != '1)
            tbl_count[slot] = tbl_count[slot] + lfu_pkg::COUNT_W'(1);
      end else if (tbl_filled < n) begin
         slot = tbl_filled;
         tbl_page[slot] = page;
         tbl_count[slot] = lfu_pkg::COUNT_W'(1);
         tbl_filled = tbl_filled + 1;
      end else begin
         // lowest-index frame with the smallest count
         slot = 0;
         for (i = 1; i < n; i++) begin
            if (tbl_count[i] < tbl_count[slot])
               slot = i;
         end
         r.ev_valid = 1'b1;
         r.ev_page = tbl_page[slot];
         tbl_page[slot] = page;
         tbl_count[slot] = lfu_pkg::COUNT_W'(1);
      end
      r.slot = slot[lfu_pkg::SLOT_W-1:0];
      return r;
   endfunction

   // hot pool around a base page, with some fully random pages mixed in
   function automatic logic [lfu_pkg::PAGE_W-1:0] pick_page(
         input int unsigned n, input logic [lfu_pkg::PAGE_W-1:0] base);
      logic [lfu_pkg::PAGE_W-1:0] p;
      if ($urandom_range(0, 9) < 3)
         p = lfu_pkg::PAGE_W'($urandom);
      else
         p = base + lfu_pkg::PAGE_W'($urandom_range(0, n + 2));
      return p;
   endfunction

   task automatic offer(input logic [lfu_pkg::PAGE_W-1:0] page);
      page_q.push_back(page);
      n_queued++;
   endtask

   // hold the sender back until every reply has come
   task automatic drain();
      while (n_taken != n_queued || replies_due.size() != 0)
         @(posedge clock);
   endtask

   // apb read of frames_in_use and compare
   task automatic check_frames(input logic [lfu_pkg::CFG_W-1:0] want);
      logic [lfu_pkg::APB_DW-1:0] got;
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= lfu_pkg::ADDR_FRAMES_IN_USE;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      if (got !== lfu_pkg::APB_DW'(want)) begin
         $display("%0t: frames_in_use read expected %0d got %0h", $time, want, got);
         n_errors++;
      end
   endtask

   // apb write of frames_in_use, then read back
   task automatic set_frames(input logic [lfu_pkg::APB_DW-1:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= lfu_pkg::ADDR_FRAMES_IN_USE;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      cfg_frames = value[lfu_pkg::CFG_W-1:0];
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      check_frames(value[lfu_pkg::CFG_W-1:0]);
   endtask

   // one random phase at a given frame count
   task automatic random_phase(input logic [lfu_pkg::APB_DW-1:0] count, input int items);
      logic [lfu_pkg::PAGE_W-1:0] base;
      int unsigned                n;
      set_frames(count);
      n = (count[lfu_pkg::CFG_W-1:0] == '0) ? 1 : int'(count[lfu_pkg::CFG_W-1:0]);
      base = lfu_pkg::PAGE_W'($urandom);
      repeat (items) offer(pick_page(n, base));
      drain();
   endtask

   // stimulus
   initial begin
      logic [lfu_pkg::PAGE_W-1:0] base;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      check_frames(lfu_pkg::FRAMES_IN_USE_RST);

      // reset frame count: fill all frames, hits, then evictions
      offer(16'h0000);
      offer(16'hFFFF);
      offer(16'h0000);
      offer(16'hFFFF);
      offer(16'hAAAA);
      offer(16'h5555);
      for (int i = 1; i <= 12; i++) offer(lfu_pkg::PAGE_W'(i));
      offer(16'h1234);
      offer(16'h1234);
      offer(16'h4321);
      drain();

      // zero acts as one frame; frames above it are ignored
      set_frames(32'h0);
      offer(16'h0000);
      offer(16'hFFFF);
      offer(16'hFFFF);
      offer(16'h0001);
      drain();

      // count above the built frames clamps; kept frames are searched again
      set_frames(32'hFFFF_FFFF);
      offer(16'hFFFF);
      offer(16'h1234);
      base = lfu_pkg::PAGE_W'($urandom);
      repeat (60) offer(pick_page(lfu_pkg::FRAMES, base));
      drain();

      random_phase(32'd1, 50);
      random_phase(32'd16, 40);
      random_phase(32'd3, 50);
      random_phase(32'd0, 30);
      random_phase(32'd31, 50);
      random_phase(32'd7, 50);
      random_phase({27'($urandom_range(0, 32'h07FF_FFFF)), 5'd12}, 50);
      random_phase($urandom_range(0, 31), 50);
      random_phase($urandom_range(0, 31), 50);

      // keep one frame hot, then evict around it
      set_frames(32'd2);
      repeat (8) offer(HOT_PAGE);
      base = lfu_pkg::PAGE_W'($urandom);
      repeat (10) offer(pick_page(2, base));
      repeat (4) offer(HOT_PAGE);
      drain();

      random_phase(32'd16, 20);

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (n_errors == 0 && replies_due.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   // request driver: bursts of items with random gaps
   int burst_left = 1;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            replies_due.push_back(lfu_access(req_page));
            n_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (page_q.size() > 0) begin
               req_valid <= 1'b1;
               req_page <= page_q.pop_front();
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result stall pattern, with one long hold-off
   int  mode = 0;
   int  mode_left = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && n_checked >= HOLD_AFTER) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 150);
         end
         mode_left--;
         case (mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // result monitor
   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_checked++;
         if (replies_due.size() == 0) begin
            $display("%0t: result with no item pending: expected none got slot %0d",
                     $time, rsp_frame_slot);
            n_errors++;
         end else begin
            want = replies_due.pop_front();
            if (rsp_hit !== want.hit) begin
               $display("%0t: hit expected %0d got %0d", $time, want.hit, rsp_hit);
               n_errors++;
            end
            if (rsp_frame_slot !== want.slot) begin
               $display("%0t: frame_slot expected %0d got %0d",
                        $time, want.slot, rsp_frame_slot);
               n_errors++;
            end
            if (rsp_evicted_valid !== want.ev_valid) begin
               $display("%0t: evicted_valid expected %0d got %0d",
                        $time, want.ev_valid, rsp_evicted_valid);
               n_errors++;
            end
            if (rsp_evicted_page !== want.ev_page) begin
               $display("%0t: evicted_page expected %h got %h",
                        $time, want.ev_page, rsp_evicted_page);
               n_errors++;
            end
         end
      end
   end

   // watchdog on cycles with no transfer on any port
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (psel && penable && pready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
         end
      end
   end

endmodule

[files.f]
rtl/lfu_pkg.sv
rtl/lfu_page_replacement.sv
dv/tb_top.sv
